// ----- src/byterun_run_length_encoder_top_macros.svh -----
// assertion macros shared by the encoder rtl
`ifndef BYTERUN_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`define BYTERUN_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle
`define BRLE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequent checked in the following cycle
`define BRLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BRLE_ASSERT_SAME(name, clk, rst, ante, cons, msg)
`define BRLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/brle_pkg.sv -----
// shared types and constants for the byterun encoder
package brle_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 8;
   localparam int unsigned CNT_W       = 3;
   localparam int unsigned FIELD_LANES = 4;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LITERAL,
      OP_REPEAT
   } op_kind_type;

   // literal: len bytes from the buffer bank, then an optional tail byte in data
   // repeat: len is the run length, data the repeated value
   typedef struct packed {
      op_kind_type       kind;
      logic              bank;
      logic [LEN_W-1:0]  len;
      logic              tail_valid;
      logic [BYTE_W-1:0] data;
   } op_type;

   typedef struct packed {
      op_type op0;
      op_type op1;
      logic   stream_end;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_VAL,
      ST_LIT,
      ST_TAIL
   } back_state_type;

endpackage

// ----- src/brle_if.sv -----
// request and response channel interfaces of the byterun encoder
interface brle_req_if;
   logic                        valid;
   logic                        ready;
   logic [brle_pkg::BYTE_W-1:0] in_byte;
   logic                        end_of_stream;

   modport source (output valid, in_byte, end_of_stream, input ready);
   modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface brle_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [brle_pkg::BYTE_W-1:0] code_byte_a;
   logic [brle_pkg::BYTE_W-1:0] code_byte_b;
   logic [brle_pkg::BYTE_W-1:0] code_byte_c;
   logic [brle_pkg::BYTE_W-1:0] code_byte_d;
   logic [brle_pkg::CNT_W-1:0]  byte_count;
   logic                        item_last;
   logic                        stream_done;

   modport source (output valid, code_byte_a, code_byte_b, code_byte_c, code_byte_d,
                   byte_count, item_last, stream_done, input ready);
   modport sink (input valid, code_byte_a, code_byte_b, code_byte_c, code_byte_d,
                 byte_count, item_last, stream_done, output ready);
endinterface

// ----- src/brle_ram.sv -----
// generic single write port ram with registered read
module brle_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/brle_front.sv -----
// front end: run detection, literal buffer writes and command issue
module brle_front #(
   parameter int unsigned MAX_RUN = 128,
   parameter int unsigned ADDR_W  = $clog2(MAX_RUN) + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [brle_pkg::BYTE_W-1:0]    in_byte,
   input  logic                           in_end,
   input  logic                           q_full,
   output logic                           q_push,
   output brle_pkg::cmd_type              q_data,
   input  brle_pkg::bank_release_type     bank_release,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [brle_pkg::BYTE_W-1:0]    wr_data
);

   localparam int unsigned IDX_W = ADDR_W - 1;

   logic [brle_pkg::BYTE_W-1:0] held_ff, held_in;
   logic                        hv_ff, hv_in;
   logic                        rep_ff, rep_in;
   logic [brle_pkg::LEN_W-1:0]  rlen_ff, rlen_in;
   logic [brle_pkg::LEN_W-1:0]  llen_ff, llen_in;
   logic                        bank_ff, bank_in;
   logic [1:0]                  busy_ff, busy_in;
   logic [1:0]                  set_busy;
   logic                        accept;
   brle_pkg::cmd_type           cmd;

   function automatic brle_pkg::cmd_type add_op(brle_pkg::cmd_type c, brle_pkg::op_type o);
      brle_pkg::cmd_type r;
      r = c;
      if (r.op0.kind == brle_pkg::OP_NONE) begin
         r.op0 = o;
      end else begin
         r.op1 = o;
      end
      return r;
   endfunction

   function automatic brle_pkg::op_type repeat_op(logic [brle_pkg::LEN_W-1:0] len,
                                                  logic [brle_pkg::BYTE_W-1:0] value);
      brle_pkg::op_type o;
      o.kind       = brle_pkg::OP_REPEAT;
      o.bank       = 1'b0;
      o.len        = len;
      o.tail_valid = 1'b0;
      o.data       = value;
      return o;
   endfunction

   function automatic brle_pkg::op_type literal_op(logic bank,
                                                   logic [brle_pkg::LEN_W-1:0] len,
                                                   logic tail_valid,
                                                   logic [brle_pkg::BYTE_W-1:0] tail);
      brle_pkg::op_type o;
      o.kind       = brle_pkg::OP_LITERAL;
      o.bank       = bank;
      o.len        = len;
      o.tail_valid = tail_valid;
      o.data       = tail;
      return o;
   endfunction

   // new beats wait while the bank being filled still drains or the queue is full
   assign in_ready = ~busy_ff[bank_ff] & ~q_full;
   assign accept   = in_valid & in_ready;

   always_comb begin
      held_in  = held_ff;
      hv_in    = hv_ff;
      rep_in   = rep_ff;
      rlen_in  = rlen_ff;
      llen_in  = llen_ff;
      bank_in  = bank_ff;
      set_busy = 2'b00;
      cmd      = '0;
      wr_en    = 1'b0;
      wr_addr  = {bank_ff, llen_ff[IDX_W-1:0]};
      wr_data  = held_ff;
      if (accept) begin
         if (!hv_ff) begin
            held_in = in_byte;
            hv_in   = 1'b1;
            rep_in  = 1'b0;
         end else if (rep_ff) begin
            if ((in_byte == held_ff) && (rlen_ff < brle_pkg::LEN_W'(MAX_RUN))) begin
               rlen_in = rlen_ff + 8'd1;
            end else begin
               cmd     = add_op(cmd, repeat_op(rlen_ff, held_ff));
               rep_in  = 1'b0;
               rlen_in = '0;
               held_in = in_byte;
            end
         end else if (in_byte == held_ff) begin
            if (llen_ff != '0) begin
               cmd               = add_op(cmd, literal_op(bank_ff, llen_ff, 1'b0, '0));
               set_busy[bank_ff] = 1'b1;
               bank_in           = ~bank_ff;
               llen_in           = '0;
            end
            rep_in  = 1'b1;
            rlen_in = 8'd2;
         end else begin
            wr_en   = 1'b1;
            llen_in = llen_ff + 8'd1;
            if ((llen_ff + 8'd1) == brle_pkg::LEN_W'(MAX_RUN)) begin
               cmd               = add_op(cmd, literal_op(bank_ff, llen_in, 1'b0, '0));
               set_busy[bank_ff] = 1'b1;
               bank_in           = ~bank_ff;
               llen_in           = '0;
            end
            held_in = in_byte;
         end
         if (in_end) begin
            if (rep_in) begin
               cmd = add_op(cmd, repeat_op(rlen_in, held_in));
            end else begin
               // last held byte goes out as the tail of the literal run
               cmd = add_op(cmd, literal_op(bank_in, llen_in, 1'b1, held_in));
               if (llen_in != '0) begin
                  set_busy[bank_in] = 1'b1;
                  bank_in           = ~bank_in;
               end
            end
            held_in = '0;
            hv_in   = 1'b0;
            rep_in  = 1'b0;
            rlen_in = '0;
            llen_in = '0;
         end
      end
      cmd.stream_end = in_end;
   end

   assign q_push = accept & (cmd.op0.kind != brle_pkg::OP_NONE);
   assign q_data = cmd;

   always_comb begin
      busy_in = busy_ff;
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end
      busy_in = busy_in | set_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         hv_ff   <= 1'b0;
         rep_ff  <= 1'b0;
         rlen_ff <= '0;
         llen_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         held_ff <= held_in;
         hv_ff   <= hv_in;
         rep_ff  <= rep_in;
         rlen_ff <= rlen_in;
         llen_ff <= llen_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- src/brle_queue.sv -----
// small command queue between front and back
module brle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brle_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output brle_pkg::cmd_type head
);

   brle_pkg::cmd_type              mem_ff [brle_pkg::QUEUE_DEPTH];
   logic [brle_pkg::QPTR_W-1:0]    wptr_ff, wptr_in;
   logic [brle_pkg::QPTR_W-1:0]    rptr_ff, rptr_in;
   logic [brle_pkg::QPTR_W:0]      count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full    = (count_ff == (brle_pkg::QPTR_W + 1)'(brle_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/brle_back.sv -----
// back end: turns commands into code bytes and packs them into result beats
module brle_back #(
   parameter int unsigned OUT_LANES = 4,
   parameter int unsigned ADDR_W    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  brle_pkg::cmd_type              q_head,
   output logic                           q_pop,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr,
   input  logic [brle_pkg::BYTE_W-1:0]    rd_data,
   output brle_pkg::bank_release_type     bank_release,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [brle_pkg::BYTE_W-1:0]    code_byte_a,
   output logic [brle_pkg::BYTE_W-1:0]    code_byte_b,
   output logic [brle_pkg::BYTE_W-1:0]    code_byte_c,
   output logic [brle_pkg::BYTE_W-1:0]    code_byte_d,
   output logic [brle_pkg::CNT_W-1:0]     byte_count,
   output logic                           item_last,
   output logic                           stream_done
);

   localparam int unsigned IDX_W = ADDR_W - 1;
   localparam int unsigned LANES =
      (OUT_LANES > brle_pkg::FIELD_LANES) ? brle_pkg::FIELD_LANES : OUT_LANES;

   brle_pkg::back_state_type    state_ff, state_in;
   brle_pkg::cmd_type           entry_ff, entry_in;
   logic                        sel_ff, sel_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   brle_pkg::op_type            cur_op;
   logic                        has_next;
   logic                        lit_last;
   logic                        gen_go;
   logic [brle_pkg::BYTE_W-1:0] hdr_byte;

   logic                        emit;
   logic                        emit_ram;
   logic [brle_pkg::BYTE_W-1:0] emit_byte;
   logic                        emit_final;

   logic                        desc_valid_ff, desc_valid_in;
   logic                        desc_ram_ff;
   logic [brle_pkg::BYTE_W-1:0] desc_byte_ff;
   logic                        desc_final_ff;
   logic                        desc_end_ff;

   logic [brle_pkg::BYTE_W-1:0] lanes_ff [brle_pkg::FIELD_LANES];
   logic [brle_pkg::BYTE_W-1:0] lanes_next [brle_pkg::FIELD_LANES];
   logic [brle_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [brle_pkg::BYTE_W-1:0] pack_byte;
   logic                        complete;
   logic                        pack_take;

   logic                        out_valid_ff, out_valid_in;
   logic [brle_pkg::BYTE_W-1:0] out_lanes_ff [brle_pkg::FIELD_LANES];
   logic [brle_pkg::CNT_W-1:0]  out_cnt_ff;
   logic                        out_last_ff;
   logic                        out_done_ff;

   assign cur_op   = sel_ff ? entry_ff.op1 : entry_ff.op0;
   assign has_next = ~sel_ff & (entry_ff.op1.kind != brle_pkg::OP_NONE);
   assign lit_last = ((brle_pkg::LEN_W'(idx_ff) + 8'd1) == cur_op.len);
   assign rd_addr  = {cur_op.bank, idx_ff};

   // repeat header is 257 - length taken mod 256, literal header is count - 1
   always_comb begin
      if (cur_op.kind == brle_pkg::OP_REPEAT) begin
         hdr_byte = 8'd1 - cur_op.len;
      end else begin
         hdr_byte = cur_op.len + brle_pkg::BYTE_W'(cur_op.tail_valid) - 8'd1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brle_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = brle_pkg::ST_HDR;
            end
         end
         brle_pkg::ST_HDR: begin
            if (gen_go) begin
               case (cur_op.kind)
                  brle_pkg::OP_REPEAT:  state_in = brle_pkg::ST_VAL;
                  brle_pkg::OP_LITERAL: state_in = (cur_op.len != '0) ? brle_pkg::ST_LIT
                                                                      : brle_pkg::ST_TAIL;
                  default:              state_in = brle_pkg::ST_IDLE;
               endcase
            end
         end
         brle_pkg::ST_VAL, brle_pkg::ST_TAIL: begin
            if (gen_go) begin
               state_in = has_next ? brle_pkg::ST_HDR : brle_pkg::ST_IDLE;
            end
         end
         brle_pkg::ST_LIT: begin
            if (gen_go && lit_last) begin
               if (cur_op.tail_valid) begin
                  state_in = brle_pkg::ST_TAIL;
               end else begin
                  state_in = has_next ? brle_pkg::ST_HDR : brle_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = brle_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop              = 1'b0;
      emit               = 1'b0;
      emit_ram           = 1'b0;
      emit_byte          = cur_op.data;
      emit_final         = 1'b0;
      rd_en              = 1'b0;
      bank_release.valid = 1'b0;
      bank_release.bank  = cur_op.bank;
      case (state_ff)
         brle_pkg::ST_IDLE: begin
            q_pop = ~q_empty;
         end
         brle_pkg::ST_HDR: begin
            emit      = 1'b1;
            emit_byte = hdr_byte;
         end
         brle_pkg::ST_VAL, brle_pkg::ST_TAIL: begin
            emit       = 1'b1;
            emit_final = ~has_next;
         end
         brle_pkg::ST_LIT: begin
            emit               = 1'b1;
            emit_ram           = 1'b1;
            emit_final         = lit_last & ~cur_op.tail_valid & ~has_next;
            rd_en              = gen_go;
            bank_release.valid = gen_go & lit_last;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // command register, op select and buffer index
   always_comb begin
      entry_in = q_pop ? q_head : entry_ff;
      sel_in   = sel_ff;
      idx_in   = idx_ff;
      if (state_ff == brle_pkg::ST_IDLE) begin
         sel_in = 1'b0;
      end else if (gen_go) begin
         if (state_ff == brle_pkg::ST_HDR) begin
            idx_in = '0;
         end
         if (state_ff == brle_pkg::ST_LIT) begin
            idx_in = idx_ff + 1'b1;
         end
         if (has_next && (state_ff == brle_pkg::ST_VAL || state_ff == brle_pkg::ST_TAIL ||
             (state_ff == brle_pkg::ST_LIT && lit_last && !cur_op.tail_valid))) begin
            sel_in = 1'b1;
         end
      end
   end

   // packer: one code byte per beat of the byte pipe
   assign pack_byte = desc_ram_ff ? rd_data : desc_byte_ff;
   assign complete  = desc_final_ff | ((cnt_ff + 3'd1) == brle_pkg::CNT_W'(LANES));
   assign pack_take = desc_valid_ff & (~complete | ~out_valid_ff | rsp_ready);
   assign gen_go    = ~desc_valid_ff | pack_take;
   assign desc_valid_in = gen_go ? emit : desc_valid_ff;

   always_comb begin
      for (int l = 0; l < brle_pkg::FIELD_LANES; l++) begin
         if (brle_pkg::CNT_W'(l) < cnt_ff) begin
            lanes_next[l] = lanes_ff[l];
         end else if (brle_pkg::CNT_W'(l) == cnt_ff) begin
            lanes_next[l] = pack_byte;
         end else begin
            lanes_next[l] = '0;
         end
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      if (pack_take) begin
         if (complete) begin
            cnt_in       = '0;
            out_valid_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen_go) begin
         desc_ram_ff   <= emit_ram;
         desc_byte_ff  <= emit_byte;
         desc_final_ff <= emit_final;
         desc_end_ff   <= entry_ff.stream_end;
      end
      entry_ff <= entry_in;
      idx_ff   <= idx_in;
      if (pack_take) begin
         if (complete) begin
            out_lanes_ff <= lanes_next;
            out_cnt_ff   <= cnt_ff + 3'd1;
            out_last_ff  <= desc_final_ff;
            out_done_ff  <= desc_final_ff & desc_end_ff;
         end else begin
            lanes_ff <= lanes_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brle_pkg::ST_IDLE;
         sel_ff        <= 1'b0;
         desc_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         desc_valid_ff <= desc_valid_in;
         cnt_ff        <= cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign code_byte_a = out_lanes_ff[0];
   assign code_byte_b = out_lanes_ff[1];
   assign code_byte_c = out_lanes_ff[2];
   assign code_byte_d = out_lanes_ff[3];
   assign byte_count  = out_cnt_ff;
   assign item_last   = out_last_ff;
   assign stream_done = out_done_ff;

endmodule

// ----- src/byterun_run_length_encoder_top.sv -----
// ByteRun (PackBits) encoder top level. Input beats are taken one per cycle
// by the front end, which holds one byte of lookahead, tracks repeat runs and
// writes literal bytes into a two-bank literal buffer (one bank of MAX_RUN
// bytes fills while the other drains). Every beat that produces code queues
// one command in a 4-entry queue; the back end pops it, turns it into code
// bytes at one byte per cycle unless the result side stalls, and packs them
// into result beats of up to OUT_LANES (at most 4) bytes. A repeat run is a
// header byte and its value, a literal run a header, its buffered bytes and
// an optional tail. Input stalls only while the queue is full or the bank to
// be filled still drains, so literal-heavy data runs near one byte per cycle
// and repeat data at one per cycle. No clearing pass is needed after reset.
`include "byterun_run_length_encoder_top_macros.svh"
module byterun_run_length_encoder_top #(
   parameter int unsigned MAX_RUN   = 128,
   parameter int unsigned OUT_LANES = 4
) (
   input  logic       clock,
   input  logic       reset,
   brle_req_if.sink   req_bus,
   brle_rsp_if.source rsp_bus
);

   localparam int unsigned ADDR_W = $clog2(MAX_RUN) + 1;
   localparam int unsigned DEPTH  = 1 << ADDR_W;
   localparam int unsigned LANES  =
      (OUT_LANES > brle_pkg::FIELD_LANES) ? brle_pkg::FIELD_LANES : OUT_LANES;

   logic                        q_push;
   logic                        q_pop;
   logic                        q_full;
   logic                        q_empty;
   brle_pkg::cmd_type           q_data;
   brle_pkg::cmd_type           q_head;
   brle_pkg::bank_release_type  bank_release;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [brle_pkg::BYTE_W-1:0] wr_data;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic [brle_pkg::BYTE_W-1:0] rd_data;
   logic                        end_beat;
   logic                        rsp_beat_ok;

   brle_front #(
      .MAX_RUN (MAX_RUN),
      .ADDR_W  (ADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .in_byte      (req_bus.in_byte),
      .in_end       (req_bus.end_of_stream),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data),
      .bank_release (bank_release),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   brle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   brle_ram #(
      .WIDTH  (brle_pkg::BYTE_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brle_back #(
      .OUT_LANES (OUT_LANES),
      .ADDR_W    (ADDR_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .bank_release (bank_release),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .code_byte_a  (rsp_bus.code_byte_a),
      .code_byte_b  (rsp_bus.code_byte_b),
      .code_byte_c  (rsp_bus.code_byte_c),
      .code_byte_d  (rsp_bus.code_byte_d),
      .byte_count   (rsp_bus.byte_count),
      .item_last    (rsp_bus.item_last),
      .stream_done  (rsp_bus.stream_done)
   );

   assign end_beat    = req_bus.valid & req_bus.ready & req_bus.end_of_stream;
   assign rsp_beat_ok = (rsp_bus.byte_count != 3'd0) &&
                        (rsp_bus.byte_count <= 3'(LANES)) &&
                        (!rsp_bus.stream_done || rsp_bus.item_last);

   `BRLE_ASSERT_SAME(a_push_has_room, clock, reset, q_push, !q_full, "push into full queue")
   `BRLE_ASSERT_NEXT(a_push_lands, clock, reset, q_push, !q_empty, "pushed command lost")
   `BRLE_ASSERT_SAME(a_end_flushes, clock, reset, end_beat, q_push, "end beat queued nothing")
   `BRLE_ASSERT_SAME(a_rsp_beat_sane, clock, reset, rsp_bus.valid, rsp_beat_ok, "bad result beat")

endmodule
